// ===== rtl/qrv_pkg.sv =====
// Shared types, fixed-point constants and the multiply helper for the quaternion rotator.
package qrv_pkg;

   // Fixed-point format of every vector and quaternion component.
   localparam int FRAC_BITS = 16;
   localparam int VEC_W     = 32;

   // Exact partial product width and the width of a four-term sum after the shift.
   localparam int PROD_W = 2 * VEC_W;
   localparam int SUM_W  = PROD_W - FRAC_BITS + 2;

   typedef logic signed [VEC_W-1:0]  word_type;
   typedef logic signed [VEC_W:0]    wide_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef prod_type [3:0]           prod4_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   // Saturation bounds of a 32-bit signed component, at sum width.
   localparam sum_type SAT_HI = SUM_W'(64'sd2147483647);
   localparam sum_type SAT_LO = SUM_W'(-64'sd2147483648);

   // Sign masks of the Hamilton product terms; bit n set means term n is subtracted.
   localparam logic [3:0] NEG_REAL = 4'b1110;
   localparam logic [3:0] NEG_P_I  = 4'b0100;
   localparam logic [3:0] NEG_P_J  = 4'b0001;
   localparam logic [3:0] NEG_P_K  = 4'b0010;
   localparam logic [3:0] NEG_R_I  = 4'b1000;
   localparam logic [3:0] NEG_R_J  = 4'b0010;
   localparam logic [3:0] NEG_R_K  = 4'b0100;

   // Extends a 32-bit component to 33 bits so that it can share the multiplier form.
   function automatic wide_type widen(input word_type a);
      return wide_type'(a);
   endfunction

   // Negates a 32-bit component exactly in 33 bits; the most negative value becomes +2^31.
   function automatic wide_type negate(input word_type a);
      wide_type w;
      w = wide_type'(a);
      return -w;
   endfunction

   // Exact signed product; magnitudes never exceed 2^62, so 64 bits hold it.
   function automatic prod_type qmul(input word_type a, input wide_type b);
      logic signed [PROD_W:0] full;
      full = (PROD_W+1)'(a) * (PROD_W+1)'(b);
      return full[PROD_W-1:0];
   endfunction

endpackage

// ===== rtl/qrv_sum_sat.sv =====
// Floor shift, signed four-term sum and 32-bit saturation of one quaternion component.
module qrv_sum_sat (
   input  qrv_pkg::prod4_type terms,
   input  logic [3:0]         neg,
   output qrv_pkg::word_type  sum,
   output logic               sat
);
   import qrv_pkg::*;

   logic signed [PROD_W-FRAC_BITS-1:0] shifted;
   sum_type                            acc;

   // Each product drops its low fraction bits, which rounds toward minus infinity.
   always_comb begin
      acc     = '0;
      shifted = '0;
      for (int n = 0; n < 4; n++) begin
         shifted = terms[n][PROD_W-1:FRAC_BITS];
         if (neg[n]) begin
            acc = acc - SUM_W'(shifted);
         end else begin
            acc = acc + SUM_W'(shifted);
         end
      end
   end

   // Clamp to the 32-bit range and report when the clamp was used.
   always_comb begin
      if (acc > SAT_HI) begin
         sum = SAT_HI[VEC_W-1:0];
         sat = 1'b1;
      end else if (acc < SAT_LO) begin
         sum = SAT_LO[VEC_W-1:0];
         sat = 1'b1;
      end else begin
         sum = acc[VEC_W-1:0];
         sat = 1'b0;
      end
   end

endmodule

// ===== rtl/quaternion_rotate_vector.sv =====
// Top level of the pipelined quaternion rotation of a 3D vector.
// Usage:
//   Each req_ transaction carries a vector (req_vec_x/y/z) and a quaternion
//   (req_quat_w/i/j/k), all signed Q16.16. Each gives exactly one rsp_
//   transaction with the vector part of q * (0,u) * conj(q) in rsp_rot_x/y/z.
//   The quaternion is not normalized, so the result also scales by |q|^2.
//   rsp_saturated is set when any component of either Hamilton product hit
//   the 32-bit limits.
// Timing:
//   Four register stages: first multiplies, first sums, second multiplies,
//   second sums into the output register. One transaction is accepted per
//   cycle while req_stall is low; the per-stage multiplier banks are
//   twelve and sixteen 32x33 products wide.
// Reset and stall:
//   Reset clears all stage valid bits; no result is pending afterwards.
//   When rsp_stall is high a valid output holds. Stages behind it keep moving
//   into empty slots, and req_stall rises only once every stage is full.
module quaternion_rotate_vector (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qrv_pkg::word_type req_vec_x,
   input  qrv_pkg::word_type req_vec_y,
   input  qrv_pkg::word_type req_vec_z,
   input  qrv_pkg::word_type req_quat_w,
   input  qrv_pkg::word_type req_quat_i,
   input  qrv_pkg::word_type req_quat_j,
   input  qrv_pkg::word_type req_quat_k,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qrv_pkg::word_type rsp_rot_x,
   output qrv_pkg::word_type rsp_rot_y,
   output qrv_pkg::word_type rsp_rot_z,
   output logic              rsp_saturated
);
   import qrv_pkg::*;

   // Stage valid bits and per-stage load enables.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   // Stage 1: products of the first Hamilton product, quaternion carried along.
   prod_type m1_ff [12];
   prod_type m1_in [12];
   word_type qw1_ff, qi1_ff, qj1_ff, qk1_ff;

   // Stage 2: saturated p = (0,u) * conj(q).
   word_type pa_ff, pb_ff, pc_ff, pd_ff;
   word_type pa_in, pb_in, pc_in, pd_in;
   logic     flag2_ff, flag2_in;
   logic     sat_pa, sat_pb, sat_pc, sat_pd;
   word_type qw2_ff, qi2_ff, qj2_ff, qk2_ff;

   // Stage 3: products of the second Hamilton product.
   prod_type m3_ff [16];
   prod_type m3_in [16];
   logic     flag3_ff;

   // Stage 4: output register.
   word_type rx_ff, ry_ff, rz_ff;
   word_type ra_in, rx_in, ry_in, rz_in;
   logic     sat4_ff, sat4_in;
   logic     sat_ra, sat_rx, sat_ry, sat_rz;

   wide_type ni, nj, nk;

   // A stage loads when it is empty or its contents move on in the same cycle.
   assign en4       = !v4_ff || !rsp_stall;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // First product: u against the conjugate, negated exactly in 33 bits.
   always_comb begin
      ni        = negate(req_quat_i);
      nj        = negate(req_quat_j);
      nk        = negate(req_quat_k);
      m1_in[0]  = qmul(req_vec_x, ni);
      m1_in[1]  = qmul(req_vec_y, nj);
      m1_in[2]  = qmul(req_vec_z, nk);
      m1_in[3]  = qmul(req_vec_x, widen(req_quat_w));
      m1_in[4]  = qmul(req_vec_y, nk);
      m1_in[5]  = qmul(req_vec_z, nj);
      m1_in[6]  = qmul(req_vec_x, nk);
      m1_in[7]  = qmul(req_vec_y, widen(req_quat_w));
      m1_in[8]  = qmul(req_vec_z, ni);
      m1_in[9]  = qmul(req_vec_x, nj);
      m1_in[10] = qmul(req_vec_y, ni);
      m1_in[11] = qmul(req_vec_z, widen(req_quat_w));
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         m1_ff  <= m1_in;
         qw1_ff <= req_quat_w;
         qi1_ff <= req_quat_i;
         qj1_ff <= req_quat_j;
         qk1_ff <= req_quat_k;
      end
   end

   // Sums of the first product; the zero real part of u drops one term each.
   qrv_sum_sat u_sum_pa (
      .terms ({m1_ff[2], m1_ff[1], m1_ff[0], prod_type'(0)}),
      .neg   (NEG_REAL),
      .sum   (pa_in),
      .sat   (sat_pa)
   );
   qrv_sum_sat u_sum_pb (
      .terms ({prod_type'(0), m1_ff[5], m1_ff[4], m1_ff[3]}),
      .neg   (NEG_P_I),
      .sum   (pb_in),
      .sat   (sat_pb)
   );
   qrv_sum_sat u_sum_pc (
      .terms ({prod_type'(0), m1_ff[8], m1_ff[7], m1_ff[6]}),
      .neg   (NEG_P_J),
      .sum   (pc_in),
      .sat   (sat_pc)
   );
   qrv_sum_sat u_sum_pd (
      .terms ({prod_type'(0), m1_ff[11], m1_ff[10], m1_ff[9]}),
      .neg   (NEG_P_K),
      .sum   (pd_in),
      .sat   (sat_pd)
   );

   assign flag2_in = sat_pa | sat_pb | sat_pc | sat_pd;

   always_ff @(posedge clock) begin
      if (en2) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         pc_ff    <= pc_in;
         pd_ff    <= pd_in;
         flag2_ff <= flag2_in;
         qw2_ff   <= qw1_ff;
         qi2_ff   <= qi1_ff;
         qj2_ff   <= qj1_ff;
         qk2_ff   <= qk1_ff;
      end
   end

   // Second product: q * p, grouped by result component.
   always_comb begin
      m3_in[0]  = qmul(qw2_ff, widen(pa_ff));
      m3_in[1]  = qmul(qi2_ff, widen(pb_ff));
      m3_in[2]  = qmul(qj2_ff, widen(pc_ff));
      m3_in[3]  = qmul(qk2_ff, widen(pd_ff));
      m3_in[4]  = qmul(qw2_ff, widen(pb_ff));
      m3_in[5]  = qmul(qi2_ff, widen(pa_ff));
      m3_in[6]  = qmul(qj2_ff, widen(pd_ff));
      m3_in[7]  = qmul(qk2_ff, widen(pc_ff));
      m3_in[8]  = qmul(qw2_ff, widen(pc_ff));
      m3_in[9]  = qmul(qi2_ff, widen(pd_ff));
      m3_in[10] = qmul(qj2_ff, widen(pa_ff));
      m3_in[11] = qmul(qk2_ff, widen(pb_ff));
      m3_in[12] = qmul(qw2_ff, widen(pd_ff));
      m3_in[13] = qmul(qi2_ff, widen(pc_ff));
      m3_in[14] = qmul(qj2_ff, widen(pb_ff));
      m3_in[15] = qmul(qk2_ff, widen(pa_ff));
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         m3_ff    <= m3_in;
         flag3_ff <= flag2_ff;
      end
   end

   // Sums of the second product; the real part only feeds the flag.
   qrv_sum_sat u_sum_ra (
      .terms ({m3_ff[3], m3_ff[2], m3_ff[1], m3_ff[0]}),
      .neg   (NEG_REAL),
      .sum   (ra_in),
      .sat   (sat_ra)
   );
   qrv_sum_sat u_sum_rx (
      .terms ({m3_ff[7], m3_ff[6], m3_ff[5], m3_ff[4]}),
      .neg   (NEG_R_I),
      .sum   (rx_in),
      .sat   (sat_rx)
   );
   qrv_sum_sat u_sum_ry (
      .terms ({m3_ff[11], m3_ff[10], m3_ff[9], m3_ff[8]}),
      .neg   (NEG_R_J),
      .sum   (ry_in),
      .sat   (sat_ry)
   );
   qrv_sum_sat u_sum_rz (
      .terms ({m3_ff[15], m3_ff[14], m3_ff[13], m3_ff[12]}),
      .neg   (NEG_R_K),
      .sum   (rz_in),
      .sat   (sat_rz)
   );

   // The real part of r is never output, but its sign bit keeps the sum in use.
   assign sat4_in = flag3_ff | sat_ra | sat_rx | sat_ry | sat_rz | (ra_in[VEC_W-1] & 1'b0);

   always_ff @(posedge clock) begin
      if (en4) begin
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         rz_ff   <= rz_in;
         sat4_ff <= sat4_in;
      end
   end

   // Result transaction outputs.
   assign rsp_valid     = v4_ff;
   assign rsp_rot_x     = rx_ff;
   assign rsp_rot_y     = ry_ff;
   assign rsp_rot_z     = rz_ff;
   assign rsp_saturated = sat4_ff;

`ifndef NO_ASSERTIONS
   // Input backpressure only happens when every stage holds a transaction.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall))
      else $error("request stalled while the pipeline has room");

   // A blocked middle stage keeps its transaction and the pa and pd parts of its p value.
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !en3) |=> (v2_ff && $stable(pa_ff) && $stable(pd_ff)))
      else $error("stage two lost or changed a blocked transaction");

   // A saturation in the first product always reaches the result flag.
   a_flag_carry: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && flag3_ff && en4) |=> rsp_saturated)
      else $error("first-product saturation not reported");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the quaternion vector rotator, with its own fixed-point predictor.
module tb_top;
   import qrv_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int RANDOM_ITEMS = 1150;
   localparam int PAUSE_AT     = 520;
   localparam int PIPE_DRAIN   = 8;
   localparam int CYCLE_LIMIT  = 600000;

   // Handy Q16.16 values.
   localparam word_type ONE  = 32'sh0001_0000;
   localparam word_type MAXW = 32'sh7FFF_FFFF;
   localparam word_type MINW = 32'sh8000_0000;
   localparam word_type COS45 = 32'sd46341;
   localparam word_type HALF  = 32'sh0000_8000;

   localparam longint WORD_HI = 64'sd2147483647;
   localparam longint WORD_LO = -64'sd2147483648;

   // How widely a random component is spread.
   typedef enum {SPREAD_FULL, SPREAD_UNIT, SPREAD_SCENE, SPREAD_CORNER} spread_type;

   // A quaternion held exactly at 64 bits while the predictor works on it.
   typedef struct packed {
      longint w;
      longint i;
      longint j;
      longint k;
   } quad_type;

   typedef struct packed {
      word_type vec_x;
      word_type vec_y;
      word_type vec_z;
      word_type quat_w;
      word_type quat_i;
      word_type quat_j;
      word_type quat_k;
   } rot_request_type;

   typedef struct packed {
      word_type rot_x;
      word_type rot_y;
      word_type rot_z;
      logic     saturated;
   } rot_result_type;

   typedef struct packed {
      rot_request_type rq;
      bit              typed;
      rot_result_type  want;
   } directed_row_type;

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     req_valid = 1'b0;
   logic     rsp_stall = 1'b0;
   word_type req_vec_x  = '0;
   word_type req_vec_y  = '0;
   word_type req_vec_z  = '0;
   word_type req_quat_w = '0;
   word_type req_quat_i = '0;
   word_type req_quat_j = '0;
   word_type req_quat_k = '0;
   logic     req_stall;
   logic     rsp_valid;
   word_type rsp_rot_x;
   word_type rsp_rot_y;
   word_type rsp_rot_z;
   logic     rsp_saturated;

   rot_result_type   rot_expected [$];
   directed_row_type directed [$];
   int               fail_count  = 0;
   int               cycle_count = 0;
   int               rsp_hold    = 0;

   quaternion_rotate_vector u_top (.*);

   always #CLK_HALF clock = ~clock;

   // Fixed-point product, rounded toward minus infinity.
   function automatic longint fx_mul(input longint a, input longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   // Clamps a sum to 32 bits and notes whether it had to.
   function automatic longint clamp32(input longint v, inout bit sat);
      if (v > WORD_HI) begin
         sat = 1'b1;
         return WORD_HI;
      end
      if (v < WORD_LO) begin
         sat = 1'b1;
         return WORD_LO;
      end
      return v;
   endfunction

   // Hamilton product a*b with every component saturated to 32 bits.
   function automatic quad_type hamilton(input quad_type a, input quad_type b, inout bit sat);
      quad_type r;
      r.w = clamp32(fx_mul(a.w, b.w) - fx_mul(a.i, b.i) - fx_mul(a.j, b.j)
                    - fx_mul(a.k, b.k), sat);
      r.i = clamp32(fx_mul(a.w, b.i) + fx_mul(a.i, b.w) + fx_mul(a.j, b.k)
                    - fx_mul(a.k, b.j), sat);
      r.j = clamp32(fx_mul(a.w, b.j) - fx_mul(a.i, b.k) + fx_mul(a.j, b.w)
                    + fx_mul(a.k, b.i), sat);
      r.k = clamp32(fx_mul(a.w, b.k) + fx_mul(a.i, b.j) - fx_mul(a.j, b.i)
                    + fx_mul(a.k, b.w), sat);
      return r;
   endfunction

   // Rotates the vector by q * (0,u) * conj(q); the conjugate is exact at 64 bits.
   function automatic rot_result_type predict_rotation(input rot_request_type rq);
      quad_type       u;
      quad_type       q;
      quad_type       qc;
      quad_type       p;
      quad_type       r;
      bit             sat;
      rot_result_type res;
      sat  = 1'b0;
      u.w  = 0;
      u.i  = rq.vec_x;
      u.j  = rq.vec_y;
      u.k  = rq.vec_z;
      q.w  = rq.quat_w;
      q.i  = rq.quat_i;
      q.j  = rq.quat_j;
      q.k  = rq.quat_k;
      qc.w = q.w;
      qc.i = -q.i;
      qc.j = -q.j;
      qc.k = -q.k;
      // The two products run one after the other so the flag collects both.
      p = hamilton(u, qc, sat);
      r = hamilton(q, p, sat);
      res.rot_x     = word_type'(r.i);
      res.rot_y     = word_type'(r.j);
      res.rot_z     = word_type'(r.k);
      res.saturated = sat;
      return res;
   endfunction

   function automatic directed_row_type row(input word_type vx, vy, vz, qw, qi, qj, qk,
                                            input bit typed,
                                            input word_type rx, ry, rz, input logic rs);
      directed_row_type d;
      d.rq    = '{vx, vy, vz, qw, qi, qj, qk};
      d.typed = typed;
      d.want  = '{rx, ry, rz, rs};
      return d;
   endfunction

   function automatic word_type rand_word(input spread_type spread);
      case (spread)
         SPREAD_FULL:  return $urandom;
         SPREAD_UNIT:  return $urandom_range(0, 2 * ONE) - ONE;
         SPREAD_SCENE: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
         default: begin
            case ($urandom_range(0, 6))
               0:       return MAXW;
               1:       return MINW;
               2:       return '0;
               3:       return ONE;
               4:       return -ONE;
               5:       return 32'sd1;
               default: return -32'sd1;
            endcase
         end
      endcase
   endfunction

   // Mostly scene-sized vectors with near-unit quaternions, then full range, corners and mixes.
   function automatic rot_request_type rand_request();
      rot_request_type rq;
      int              roll;
      spread_type      vs;
      spread_type      qs;
      bit              mixed;
      roll  = $urandom_range(0, 99);
      mixed = (roll >= 80);
      if (roll < 55) begin
         vs = SPREAD_SCENE;
         qs = SPREAD_UNIT;
      end else if (roll < 70) begin
         vs = SPREAD_FULL;
         qs = SPREAD_FULL;
      end else begin
         vs = SPREAD_CORNER;
         qs = SPREAD_CORNER;
      end
      rq.vec_x  = rand_word(mixed ? spread_type'($urandom_range(0, 3)) : vs);
      rq.vec_y  = rand_word(mixed ? spread_type'($urandom_range(0, 3)) : vs);
      rq.vec_z  = rand_word(mixed ? spread_type'($urandom_range(0, 3)) : vs);
      rq.quat_w = rand_word(mixed ? spread_type'($urandom_range(0, 3)) : qs);
      rq.quat_i = rand_word(mixed ? spread_type'($urandom_range(0, 3)) : qs);
      rq.quat_j = rand_word(mixed ? spread_type'($urandom_range(0, 3)) : qs);
      rq.quat_k = rand_word(mixed ? spread_type'($urandom_range(0, 3)) : qs);
      return rq;
   endfunction

   // Gap lengths: mostly short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return $urandom_range(1, 3);
      if (roll < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Stretches of the run in which one side never idles.
   function automatic bit quiet_phase(input int which);
      return ((cycle_count / 256) % 4) == which;
   endfunction

   // Presents one transaction, holds it until accepted, and records what it should produce.
   task automatic send_request(input rot_request_type rq, input bit typed,
                               input rot_result_type want);
      req_valid  <= 1'b1;
      req_vec_x  <= rq.vec_x;
      req_vec_y  <= rq.vec_y;
      req_vec_z  <= rq.vec_z;
      req_quat_w <= rq.quat_w;
      req_quat_i <= rq.quat_i;
      req_quat_j <= rq.quat_j;
      req_quat_k <= rq.quat_k;
      do @(posedge clock); while (req_stall);
      rot_expected.push_back(typed ? want : predict_rotation(rq));
   endtask

   task automatic sender_gap();
      int gap;
      gap = (quiet_phase(2) || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic check_field(input string name, input word_type want, input word_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result();
      rot_result_type want;
      if (rot_expected.size() == 0) begin
         $error("rsp transaction with no expectation pending");
         fail_count++;
      end else begin
         want = rot_expected.pop_front();
         check_field("rot_x", want.rot_x, rsp_rot_x);
         check_field("rot_y", want.rot_y, rsp_rot_y);
         check_field("rot_z", want.rot_z, rsp_rot_z);
         check_field("saturated", word_type'(want.saturated), word_type'(rsp_saturated));
      end
   endtask

   // Watchdog, result checker and random stall on the result side.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall)
         check_result();
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else if (quiet_phase(1) || $urandom_range(0, 9) < 7) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_hold = pick_gap() - 1;
         rsp_stall <= 1'b1;
      end
   end

   // Stimulus: the directed table first, then random transactions, then the drain.
   initial begin
      rot_result_type none;
      none = '0;

      // All zero: nothing to rotate.
      directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0));
      // The identity quaternion leaves the vector alone, even at the extremes.
      directed.push_back(row(ONE, 2 * ONE, -3 * ONE, ONE, 0, 0, 0,
                             1'b1, ONE, 2 * ONE, -3 * ONE, 1'b0));
      directed.push_back(row(MAXW, MAXW, MAXW, ONE, 0, 0, 0, 1'b1, MAXW, MAXW, MAXW, 1'b0));
      directed.push_back(row(MINW, MINW, MINW, ONE, 0, 0, 0, 1'b1, MINW, MINW, MINW, 1'b0));
      // A real part of minus one is the same rotation.
      directed.push_back(row(5, -7, 9, -ONE, 0, 0, 0, 1'b1, 5, -7, 9, 1'b0));
      // A zero quaternion or a zero vector gives a zero result.
      directed.push_back(row(MAXW, MINW, MAXW, 0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0));
      directed.push_back(row(0, 0, 0, MAXW, MAXW, MAXW, MAXW, 1'b1, 0, 0, 0, 1'b0));
      // Half a turn about x flips y and z.
      directed.push_back(row(ONE, 2 * ONE, 3 * ONE, 0, ONE, 0, 0,
                             1'b1, ONE, -2 * ONE, -3 * ONE, 1'b0));
      // A real part of two scales by four, and saturates at the extremes.
      directed.push_back(row(ONE, ONE, -ONE, 2 * ONE, 0, 0, 0,
                             1'b1, 4 * ONE, 4 * ONE, -4 * ONE, 1'b0));
      directed.push_back(row(MAXW, MAXW, MAXW, 2 * ONE, 0, 0, 0,
                             1'b1, MAXW, MAXW, MAXW, 1'b1));
      directed.push_back(row(MINW, MINW, MINW, 2 * ONE, 0, 0, 0,
                             1'b1, MINW, MINW, MINW, 1'b1));
      // Extremes everywhere, including conjugates of the most negative value.
      directed.push_back(row(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW,
                             1'b0, 0, 0, 0, 1'b0));
      directed.push_back(row(MINW, MINW, MINW, MINW, MINW, MINW, MINW,
                             1'b0, 0, 0, 0, 1'b0));
      directed.push_back(row(ONE, 0, 0, 0, MINW, 0, 0, 1'b0, 0, 0, 0, 1'b0));
      directed.push_back(row(1, -1, 1, ONE, MINW, MINW, MINW, 1'b0, 0, 0, 0, 1'b0));
      directed.push_back(row(MINW, MINW, MINW, -ONE, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0));
      // Quarter turn about z, and rounding of small negative products.
      directed.push_back(row(ONE, 0, 0, COS45, 0, 0, COS45, 1'b0, 0, 0, 0, 1'b0));
      directed.push_back(row(-1, -1, -1, HALF, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0));
      // Alternating bit patterns.
      directed.push_back(row(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                             32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                             1'b0, 0, 0, 0, 1'b0));
      directed.push_back(row(32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                             32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                             1'b0, 0, 0, 0, 1'b0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < directed.size(); n++) begin
         send_request(directed[n].rq, directed[n].typed, directed[n].want);
         sender_gap();
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Once mid-run, let the pipeline empty completely before going on.
         if (n == PAUSE_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (rot_expected.size() != 0);
         end
         send_request(rand_request(), 1'b0, none);
         sender_gap();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (rot_expected.size() != 0);
      repeat (PIPE_DRAIN) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
